// ===== sv/spf_pkg.sv =====
// Package for the stepper position follower: register indexes, port widths
// and the status struct of the shared divider. No dependencies.
package spf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_W      = 40;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_INPUT_SOURCE   = 3'd0;
    localparam t_cfg_idx CFG_INIT_DIRECTION = 3'd1;
    localparam t_cfg_idx CFG_ADC_MIN        = 3'd2;
    localparam t_cfg_idx CFG_ADC_MAX        = 3'd3;
    localparam t_cfg_idx CFG_RANGE_MIN      = 3'd4;
    localparam t_cfg_idx CFG_RANGE_MAX      = 3'd5;
    localparam t_cfg_idx CFG_MAX_STEPS      = 3'd6;
    localparam t_cfg_idx CFG_STEP_PERIOD    = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/spf_divider.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on spf_pkg for the status struct.
module spf_divider #(
    parameter int DV_W = 40,
    parameter int DS_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DV_W-1:0]   i_dividend,
    input  logic [DS_W-1:0]   i_divisor,
    output spf_pkg::t_div_stat o_stat,
    output logic [DV_W-1:0]   o_quotient
);
    import spf_pkg::*;

    localparam int CW = $clog2(DV_W + 1);

    logic [DS_W:0]   r_rem;
    logic [DV_W-1:0] r_quo;
    logic [DS_W-1:0] r_dsr;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DS_W:0]   w_shift;
    logic            w_ge;

    assign w_shift = {r_rem[DS_W-1:0], r_quo[DV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
                r_cnt  <= CW'(DV_W);
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_shift - {1'b0, r_dsr}) : w_shift;
                r_quo <= {r_quo[DV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== sv/stepper_position_follower_unit.sv =====
// Stepper step/dir setpoint follower: sequencer, sample buffer and step logic.
// Depends on spf_pkg and spf_divider.
//
// channel  | direction | signals                 | contents
// s_axis   | in        | tvalid tready tdata     | now_us, adc_sample, software_input, stop
// m_axis   | out       | tvalid tready tdata     | step, dir, enable, position, target, homing
// cfg      | in        | we index data           | eight registers, write only
//
// A tick scales the target with the serial divider when the range span and the step
// count are positive. A tick that fills the sample buffer first sums the buffer and,
// if the ADC span is nonzero, runs the mapping division through the same divider.
// Reset is synchronous. Input is not ready while a tick is processed; a result
// waits in the output register and stalls only the end of the next tick.
module stepper_position_follower_unit #(
    parameter int SAMPLE_COUNT = 8,
    parameter int ADC_BITS     = 10,
    parameter int HIGH_TIME_US = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // now_us[31:0], adc_sample, software_input, stop_request, zero fill
    input  logic [((49+ADC_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // step_level, dir_level, enable_level, position[15:0], target[15:0], homing
    output logic [spf_pkg::OUT_W-1:0]  o_m_axis_tdata,
    input  logic                       i_cfg_we,
    input  spf_pkg::t_cfg_idx          i_cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spf_pkg::*;

    localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
    localparam int SLOT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int NMIN_W = 10 + CNT_W;
    localparam int DIFF_W = ((SUM_W > NMIN_W) ? SUM_W : NMIN_W) + 1;
    localparam int PROD_W = DIFF_W + 17;
    localparam int NUM_W  = PROD_W + 8;
    localparam int DEN_W  = 11 + CNT_W;
    localparam int DV_W   = (NUM_W > 40) ? NUM_W : 40;
    localparam int DS_W   = (DEN_W > 24) ? DEN_W : 24;
    localparam int SW_LSB = 32 + ADC_BITS;
    localparam int STOP_B = SW_LSB + 16;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_MAP, S_MAPD, S_DIV1, S_HOME, S_MUL2, S_DIV2, S_STEP, S_OUT
    } t_state;

    // configuration
    logic        r_input_source, r_init_dir;
    logic [9:0]  r_adc_min, r_adc_max;
    logic signed [15:0] r_range_min, r_range_max;
    logic [15:0] r_max_steps;
    logic [19:0] r_period;

    t_state r_state;
    logic [31:0] r_now;
    logic        r_stop;
    logic        r_init_done, r_homing, r_step, r_dir, r_en;
    logic [15:0] r_pos, r_tgt;
    logic [31:0] r_pulse;
    logic signed [31:0] r_sp;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [ADC_BITS-1:0] r_rdata;
    logic [ADC_BITS-1:0] r_mem [SAMPLE_COUNT];
    logic signed [PROD_W-1:0] r_prod;
    logic        r_neg;
    logic        r_dstart;
    logic [DV_W-1:0] r_dvd;
    logic [DS_W-1:0] r_dsr;
    logic        r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    t_div_stat   w_dstat;
    logic [DV_W-1:0] w_quo;

    logic signed [31:0] w_lo, w_hi;
    logic signed [16:0] w_span;
    logic [NMIN_W-1:0]  w_nmin;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [10:0] w_adiff;
    logic signed [DEN_W-1:0] w_den;
    logic [DEN_W-1:0]   w_den_mag;
    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]   w_num_mag;
    logic signed [DV_W:0]   w_qs;
    logic signed [DV_W+1:0] w_map;
    logic signed [31:0] w_map_sat;
    logic signed [31:0] w_hv, w_clamp;
    logic        w_home_end;
    logic [31:0] w_off;
    logic [SLOT_W:0] w_slot_inc;
    logic [31:0] w_elapsed;
    logic        n_step, n_dir, n_en;
    logic [15:0] n_pos;
    logic [31:0] n_pulse;

    assign w_lo   = {{8{r_range_min[15]}}, r_range_min, 8'h00};
    assign w_hi   = {{8{r_range_max[15]}}, r_range_max, 8'h00};
    assign w_span = 17'(r_range_max) - 17'(r_range_min);
    assign w_nmin = NMIN_W'(r_adc_min) * NMIN_W'(SAMPLE_COUNT);
    assign w_diff = $signed(DIFF_W'(r_sum)) - $signed(DIFF_W'(w_nmin));
    assign w_adiff = $signed({1'b0, r_adc_max}) - $signed({1'b0, r_adc_min});
    assign w_den  = $signed(DEN_W'(w_adiff)) * $signed(DEN_W'(SAMPLE_COUNT));
    assign w_den_mag = w_den[DEN_W-1] ? DEN_W'(-w_den) : DEN_W'(w_den);
    assign w_num  = $signed(NUM_W'(r_prod)) <<< 8;
    assign w_num_mag = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
    assign w_qs   = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_map  = $signed((DV_W+2)'(w_qs)) + $signed((DV_W+2)'(w_lo));
    assign w_slot_inc = (SLOT_W+1)'(r_slot) + 1'b1;

    always_comb begin
        if (w_map > $signed((DV_W+2)'(32'sh7FFFFFFF))) begin
            w_map_sat = 32'sh7FFFFFFF;
        end else if (w_map < $signed((DV_W+2)'(-33'sh80000000))) begin
            w_map_sat = 32'sh80000000;
        end else begin
            w_map_sat = w_map[31:0];
        end
    end

    always_comb begin
        w_hv = r_sp;
        w_home_end = 1'b0;
        if (r_homing) begin
            if (!r_init_dir) begin
                w_hv = w_lo;
                w_home_end = (r_pos == 16'd0);
            end else begin
                w_hv = w_hi;
                w_home_end = (r_pos == r_max_steps);
            end
        end
        if (w_hv < w_lo) begin
            w_clamp = w_lo;
        end else if (w_hv > w_hi) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = w_hv;
        end
    end

    assign w_off = r_sp - w_lo;
    assign w_elapsed = r_now - r_pulse;

    always_comb begin
        n_step  = r_step;
        n_dir   = r_dir;
        n_pos   = r_pos;
        n_pulse = r_pulse;
        n_en    = r_en;
        if (r_pos != r_tgt) begin
            n_dir = (r_pos > r_tgt);
            if (r_step) begin
                if (w_elapsed >= 32'(HIGH_TIME_US)) n_step = 1'b0;
            end else if (w_elapsed >= {12'd0, r_period}) begin
                n_pulse = r_now;
                n_step  = 1'b1;
                if (!n_dir) begin
                    if (r_pos < r_max_steps) n_pos = r_pos + 16'd1;
                end else begin
                    if (r_pos != 16'd0) n_pos = r_pos - 16'd1;
                end
            end
        end
        if (r_stop) begin
            n_en   = 1'b0;
            n_step = 1'b0;
        end
    end

    spf_divider #(.DV_W(DV_W), .DS_W(DS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dvd),
        .i_divisor  (r_dsr),
        .o_stat     (w_dstat),
        .o_quotient (w_quo)
    );

    // sample buffer, written at the input transfer when the ADC input is selected
    always_ff @(posedge i_clk) begin
        if (i_rst_n && o_s_axis_tready && i_s_axis_tvalid && r_input_source)
            r_mem[r_slot] <= i_s_axis_tdata[SW_LSB-1:32];
        r_rdata <= r_mem[r_cnt[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_source <= 1'b0;
            r_init_dir     <= 1'b0;
            r_adc_min      <= 10'd0;
            r_adc_max      <= 10'd1023;
            r_range_min    <= 16'sd0;
            r_range_max    <= 16'sd100;
            r_max_steps    <= 16'd200;
            r_period       <= 20'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INPUT_SOURCE:   r_input_source <= i_cfg_data[0];
                CFG_INIT_DIRECTION: r_init_dir     <= i_cfg_data[0];
                CFG_ADC_MIN:        r_adc_min      <= i_cfg_data[9:0];
                CFG_ADC_MAX:        r_adc_max      <= i_cfg_data[9:0];
                CFG_RANGE_MIN:      r_range_min    <= $signed(i_cfg_data[15:0]);
                CFG_RANGE_MAX:      r_range_max    <= $signed(i_cfg_data[15:0]);
                CFG_MAX_STEPS:      r_max_steps    <= i_cfg_data[15:0];
                CFG_STEP_PERIOD:    r_period       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_done <= 1'b0;
            r_homing    <= 1'b1;
            r_slot      <= '0;
            r_sp        <= 32'sd0;
            r_pos       <= 16'd0;
            r_tgt       <= 16'd0;
            r_step      <= 1'b0;
            r_dir       <= 1'b0;
            r_en        <= 1'b1;
            r_pulse     <= 32'd0;
            r_cnt       <= '0;
            r_dstart    <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_dstart <= (r_state == S_MAPD) || (r_state == S_MUL2);
            if (r_state == S_OUT && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_now  <= i_s_axis_tdata[31:0];
                        r_stop <= i_s_axis_tdata[STOP_B];
                        if (!r_init_done) begin
                            r_pos       <= r_init_dir ? 16'd0 : r_max_steps;
                            r_init_done <= 1'b1;
                        end
                        if (r_input_source) begin
                            if (w_slot_inc >= (SLOT_W+1)'(SAMPLE_COUNT)) begin
                                r_slot  <= '0;
                                r_cnt   <= '0;
                                r_sum   <= '0;
                                r_state <= S_SUM;
                            end else begin
                                r_slot  <= w_slot_inc[SLOT_W-1:0];
                                r_state <= S_HOME;
                            end
                        end else begin
                            r_sp    <= 32'(signed'(i_s_axis_tdata[STOP_B-1:SW_LSB])) <<< 8;
                            r_state <= S_HOME;
                        end
                    end
                end
                S_SUM: begin
                    // read data is registered, so it lags the address
                    if (r_cnt != '0) r_sum <= r_sum + SUM_W'(r_rdata);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SAMPLE_COUNT)) r_state <= S_MAP;
                end
                S_MAP: begin
                    if (w_den == '0) begin
                        r_sp    <= w_lo;
                        r_state <= S_HOME;
                    end else begin
                        r_prod  <= $signed(PROD_W'(w_diff)) * $signed(PROD_W'(w_span));
                        r_state <= S_MAPD;
                    end
                end
                S_MAPD: begin
                    r_neg    <= w_num[NUM_W-1] ^ w_den[DEN_W-1];
                    r_dvd    <= DV_W'(w_num_mag);
                    r_dsr    <= DS_W'(w_den_mag);
                    r_state  <= S_DIV1;
                end
                S_DIV1: begin
                    if (w_dstat.done) begin
                        r_sp    <= w_map_sat;
                        r_state <= S_HOME;
                    end
                end
                S_HOME: begin
                    r_sp <= w_clamp;
                    if (w_home_end) r_homing <= 1'b0;
                    if (w_span > 17'sd0 && r_max_steps != 16'd0) begin
                        r_state <= S_MUL2;
                    end else begin
                        r_tgt   <= 16'd0;
                        r_state <= S_STEP;
                    end
                end
                S_MUL2: begin
                    r_dvd    <= DV_W'(w_off[23:0]) * DV_W'(r_max_steps);
                    r_dsr    <= DS_W'({w_span[15:0], 8'h00});
                    r_neg    <= 1'b0;
                    r_state  <= S_DIV2;
                end
                S_DIV2: begin
                    if (w_dstat.done) begin
                        r_tgt   <= (w_quo > DV_W'(r_max_steps)) ? r_max_steps : w_quo[15:0];
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_step  <= n_step;
                    r_dir   <= n_dir;
                    r_pos   <= n_pos;
                    r_pulse <= n_pulse;
                    r_en    <= n_en;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data  <= {4'd0, r_homing, r_tgt, r_pos, r_en, r_dir, r_step};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dstat.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider result outside a division state");
    a_homing_no_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(r_homing))
        else $error("homing restarted");
    a_enable_no_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(r_en))
        else $error("driver enable set again");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for stepper_position_follower_unit: drives ticks over the input stream,
// predicts every result transfer in step with the block and checks them field by field.
// Depends on spf_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module testbench;
    import spf_pkg::*;

    localparam int SAMPLES = 8;
    localparam int HIGH_US = 5;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic        step;
        logic        dir;
        logic        enable;
        logic [15:0] position;
        logic [15:0] target;
        logic        homing;
    } t_follow;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_INPUT_SOURCE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_follow     pending_moves[$];
    int          errors = 0;
    bit          quiet = 0;
    bit          hold_go = 0;
    bit          hold_seen = 0;
    int          hold_left = 0;
    logic [31:0] clock_us = 32'd0;

    // predicted state and registers
    bit          f_src, f_dir_init;
    logic [9:0]  f_adc_min, f_adc_max;
    int          f_rng_min, f_rng_max;
    logic [15:0] f_max_steps;
    logic [19:0] f_period;
    bit          f_init, f_homing, f_step, f_dir, f_enable;
    logic [9:0]  f_store[SAMPLES];
    int          f_slot;
    int          f_setpoint;
    logic [15:0] f_pos;
    logic [31:0] f_pulse_start;

    always #2 i_clk = ~i_clk;

    stepper_position_follower_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // now_us[31:0], adc_sample[9:0], software_input[15:0], stop_request, zero fill
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // step_level, dir_level, enable_level, position[15:0], target[15:0], homing
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0 || hold_go != hold_seen)
            m_ready <= 1'b0;
        else if (quiet)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        t_follow e;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: unexpected transfer %h", $realtime, m_data);
                errors++;
            end else begin
                e = pending_moves.pop_front();
                if (m_data[0] !== e.step || m_data[1] !== e.dir || m_data[2] !== e.enable ||
                    m_data[18:3] !== e.position || m_data[34:19] !== e.target ||
                    m_data[35] !== e.homing) begin
                    $display("%0t: expected step %b dir %b en %b pos %0d tgt %0d hom %b",
                             $realtime, e.step, e.dir, e.enable, e.position, e.target,
                             e.homing);
                    $display("%0t: actual   step %b dir %b en %b pos %0d tgt %0d hom %b",
                             $realtime, m_data[0], m_data[1], m_data[2], m_data[18:3],
                             m_data[34:19], m_data[35]);
                    errors++;
                end
            end
        end
    end

    task automatic predict_reset();
        f_src = 0; f_dir_init = 0; f_adc_min = 0; f_adc_max = 1023;
        f_rng_min = 0; f_rng_max = 100; f_max_steps = 200; f_period = 1000;
        f_init = 0; f_homing = 1; f_step = 0; f_dir = 0; f_enable = 1;
        foreach (f_store[i]) f_store[i] = '0;
        f_slot = 0; f_setpoint = 0; f_pos = 0; f_pulse_start = 0;
    endtask

    task automatic follow_tick(input logic [31:0] now, input logic [9:0] adc,
                               input logic signed [15:0] sw, input logic stp);
        longint lo, hi, span, sum, den, num, t;
        logic [31:0] el;
        logic [15:0] tgt;
        bit down;
        t_follow e;
        lo = longint'(f_rng_min) * 256;
        hi = longint'(f_rng_max) * 256;
        span = longint'(f_rng_max) - longint'(f_rng_min);
        tgt = 0;
        if (!f_init) begin
            f_pos = f_dir_init ? 16'd0 : f_max_steps;
            f_init = 1;
        end
        if (f_src) begin
            f_store[f_slot] = adc;
            f_slot++;
            if (f_slot >= SAMPLES) begin
                f_slot = 0;
                sum = 0;
                foreach (f_store[i]) sum += f_store[i];
                den = SAMPLES * (longint'(f_adc_max) - longint'(f_adc_min));
                if (den == 0) begin
                    f_setpoint = f_rng_min * 256;
                end else begin
                    num = (sum - SAMPLES * longint'(f_adc_min)) * span * 256;
                    t = num / den + lo;
                    if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
                    if (t < -64'sh80000000) t = -64'sh80000000;
                    f_setpoint = int'(t);
                end
            end
        end else begin
            f_setpoint = int'(sw) * 256;
        end
        if (f_homing) begin
            if (!f_dir_init) begin
                f_setpoint = int'(lo);
                if (f_pos == 0) f_homing = 0;
            end else begin
                f_setpoint = int'(hi);
                if (f_pos == f_max_steps) f_homing = 0;
            end
        end
        if (f_setpoint < lo) f_setpoint = int'(lo);
        else if (f_setpoint > hi) f_setpoint = int'(hi);
        if (span > 0 && f_max_steps > 0) begin
            t = (longint'(f_setpoint) - lo) * longint'(f_max_steps) / (span * 256);
            if (t < 0) t = 0;
            if (t > longint'(f_max_steps)) t = f_max_steps;
            tgt = t[15:0];
        end
        if (f_pos != tgt) begin
            down = (f_pos > tgt);
            f_dir = down;
            el = now - f_pulse_start;
            if (f_step) begin
                if (el >= HIGH_US) f_step = 0;
            end else if (el >= {12'd0, f_period}) begin
                f_pulse_start = now;
                f_step = 1;
                if (!down && f_pos < f_max_steps) f_pos++;
                else if (down && f_pos > 0) f_pos--;
            end
        end
        if (stp) begin
            f_enable = 0;
            f_step = 0;
        end
        e.step = f_step; e.dir = f_dir; e.enable = f_enable;
        e.position = f_pos; e.target = tgt; e.homing = f_homing;
        pending_moves.push_back(e);
    endtask

    task automatic send_tick(input logic [31:0] now, input logic [9:0] adc,
                             input logic [15:0] sw, input logic stp);
        if (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {5'd0, stp, sw, adc, now};
        do @(posedge i_clk); while (!s_ready);
        follow_tick(now, adc, sw, stp);
    endtask

    // next timestamp: mostly small advances scaled to the step period (at most 86), now and then a jump
    task automatic tick_random(input logic [9:0] adc, input logic [15:0] sw);
        if ($urandom_range(29) == 0)
            clock_us = $urandom();
        else
            clock_us += $urandom_range(0, (f_period > 40 ? 40 : f_period) * 2 + 6);
        send_tick(clock_us, adc, sw, 1'b0);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_INPUT_SOURCE:   f_src = val[0];
            CFG_INIT_DIRECTION: f_dir_init = val[0];
            CFG_ADC_MIN:        f_adc_min = val[9:0];
            CFG_ADC_MAX:        f_adc_max = val[9:0];
            CFG_RANGE_MIN:      f_rng_min = int'($signed(val[15:0]));
            CFG_RANGE_MAX:      f_rng_max = int'($signed(val[15:0]));
            CFG_MAX_STEPS:      f_max_steps = val[15:0];
            default:            f_period = val;
        endcase
    endtask

    task automatic set_range(input int lo, input int hi, input int steps, input int period);
        cfg_write(CFG_RANGE_MIN, lo[15:0]);
        cfg_write(CFG_RANGE_MAX, hi[15:0]);
        cfg_write(CFG_MAX_STEPS, steps[15:0]);
        cfg_write(CFG_STEP_PERIOD, period[19:0]);
    endtask

    task automatic test_homing();
        int n;
        set_range(0, 100, 12, 3);
        cfg_write(CFG_INIT_DIRECTION, 0);
        n = 0;
        clock_us = 32'hFFFF_FFE0;
        while (f_homing && n < 80) begin
            clock_us += 4;
            send_tick(clock_us, 10'd0, 16'd50, 1'b0);
            n++;
        end
        wait_idle();
        cfg_write(CFG_INIT_DIRECTION, 1);
    endtask

    task automatic test_software_extremes();
        set_range(-32768, 32767, 65535, 0);
        send_tick(clock_us + 1, 10'd0, 16'h8000, 1'b0);
        send_tick(clock_us + 2, 10'h3FF, 16'h7FFF, 1'b0);
        send_tick(clock_us + 3, 10'd0, 16'h0000, 1'b0);
        send_tick(32'hFFFF_FFFF, 10'd0, 16'h7FFF, 1'b0);
        send_tick(32'h0000_0002, 10'd0, 16'hFFFF, 1'b0);
        clock_us = 2;
        wait_idle();
        // reversed range, then zero travel
        set_range(50, -50, 100, 1000000);
        send_tick(clock_us + 7, 10'd0, 16'd10, 1'b0);
        send_tick(clock_us + 9, 10'd0, 16'hFFC0, 1'b0);
        wait_idle();
        set_range(-20, 20, 0, 1);
        send_tick(clock_us + 11, 10'd0, 16'd5, 1'b0);
        send_tick(clock_us + 13, 10'd0, 16'd30, 1'b0);
        clock_us += 13;
        wait_idle();
    endtask

    task automatic test_analog();
        set_range(-100, 100, 50, 2);
        cfg_write(CFG_ADC_MIN, 0);
        cfg_write(CFG_ADC_MAX, 1023);
        cfg_write(CFG_INPUT_SOURCE, 1);
        repeat (8) tick_random(10'h3FF, 16'd0);
        repeat (8) tick_random(10'h000, 16'd0);
        wait_idle();
        cfg_write(CFG_ADC_MIN, 300);
        cfg_write(CFG_ADC_MAX, 300);
        repeat (8) tick_random(10'd512, 16'd0);
        wait_idle();
        cfg_write(CFG_ADC_MIN, 1023);
        cfg_write(CFG_ADC_MAX, 0);
        repeat (8) tick_random(10'd100, 16'd0);
        wait_idle();
    endtask

    task automatic test_random();
        int lo, hi, steps, period;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                set_range(-32768, 32767, 65535, 1);
            end else begin
                lo = $urandom_range(0, 400) - 200;
                hi = ($urandom_range(9) == 0) ? lo - 5 : lo + $urandom_range(1, 300);
                steps = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 300);
                period = $urandom_range(0, 20);
                set_range(lo, hi, steps, period);
            end
            cfg_write(CFG_INPUT_SOURCE, ph % 2);
            cfg_write(CFG_ADC_MIN, $urandom_range(0, 200));
            cfg_write(CFG_ADC_MAX, ($urandom_range(7) == 0) ? f_adc_min :
                                   $urandom_range(600, 1023));
            cfg_write(CFG_INIT_DIRECTION, $urandom_range(1));
            quiet = (ph == 5);
            for (int k = 0; k < 60; k++) begin
                if (ph == 2 && k == 10) hold_go = ~hold_go;
                if (ph == 4 && k == 30) wait_idle();
                if ($urandom_range(3) == 0)
                    tick_random($urandom(), $urandom());
                else
                    tick_random($urandom(), $urandom_range(0, f_rng_max - f_rng_min + 20)
                                + f_rng_min - 10);
            end
            quiet = 0;
            wait_idle();
        end
    endtask

    task automatic test_stop();
        clock_us += 50;
        send_tick(clock_us, 10'd0, f_rng_max[15:0], 1'b1);
        repeat (4) tick_random($urandom(), $urandom());
        wait_idle();
    endtask

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        predict_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_homing();
        test_software_extremes();
        test_analog();
        test_random();
        test_stop();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
